@@ rtl/keyboard_line_editor_top_macros.svh @@
// Assertion macros used by the line editor datapath.
`ifndef KEYBOARD_LINE_EDITOR_TOP_MACROS_SVH
`define KEYBOARD_LINE_EDITOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kle_pkg.sv @@
package kle_pkg;

	localparam int LINE_CHARS  = 32;
	localparam int POS_W       = 5;
	localparam int CHAR_W      = 7;
	localparam int KEY_W       = 8;
	localparam int STORE_DEPTH = 1 << POS_W;
	localparam int CAP_INT     = (LINE_CHARS - 1 > STORE_DEPTH - 1) ?
		STORE_DEPTH - 1 : LINE_CHARS - 1;
	localparam logic [POS_W-1:0] CAPACITY = POS_W'(CAP_INT);

	// HID keycodes
	localparam logic [KEY_W-1:0] KEY_NONE     = 8'h00;
	localparam logic [KEY_W-1:0] KEY_A        = 8'h04;
	localparam logic [KEY_W-1:0] KEY_Z        = 8'h1D;
	localparam logic [KEY_W-1:0] KEY_1        = 8'h1E;
	localparam logic [KEY_W-1:0] KEY_0        = 8'h27;
	localparam logic [KEY_W-1:0] KEY_ENTER    = 8'h28;
	localparam logic [KEY_W-1:0] KEY_ESC      = 8'h29;
	localparam logic [KEY_W-1:0] KEY_BKSP     = 8'h2A;
	localparam logic [KEY_W-1:0] KEY_SPACE    = 8'h2C;
	localparam logic [KEY_W-1:0] KEY_MINUS    = 8'h2D;
	localparam logic [KEY_W-1:0] KEY_EQUAL    = 8'h2E;
	localparam logic [KEY_W-1:0] KEY_LBRACKET = 8'h2F;
	localparam logic [KEY_W-1:0] KEY_RBRACKET = 8'h30;
	localparam logic [KEY_W-1:0] KEY_BSLASH   = 8'h31;
	localparam logic [KEY_W-1:0] KEY_SEMI     = 8'h33;
	localparam logic [KEY_W-1:0] KEY_QUOTE    = 8'h34;
	localparam logic [KEY_W-1:0] KEY_GRAVE    = 8'h35;
	localparam logic [KEY_W-1:0] KEY_COMMA    = 8'h36;
	localparam logic [KEY_W-1:0] KEY_PERIOD   = 8'h37;
	localparam logic [KEY_W-1:0] KEY_SLASH    = 8'h38;
	localparam logic [KEY_W-1:0] KEY_RIGHT    = 8'h4F;
	localparam logic [KEY_W-1:0] KEY_LEFT     = 8'h50;

	// left or right shift
	localparam logic [KEY_W-1:0] SHIFT_MASK = 8'h22;

	localparam logic [CHAR_W-1:0] CHAR_NUL     = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

	// event kinds
	localparam logic [1:0] EV_IGNORED = 2'd0;
	localparam logic [1:0] EV_EDIT    = 2'd1;
	localparam logic [1:0] EV_SEND    = 2'd2;
	localparam logic [1:0] EV_ESCAPE  = 2'd3;

	// shifted number row: ! @ # $ % ^ & * ( )
	localparam logic [CHAR_W-1:0] SHIFT_DIGITS [10] = '{
		7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
	};

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic [KEY_W-1:0] modifier_bits;
	} kle_in_t;

	typedef struct packed {
		logic [1:0]        event_kind;
		logic [CHAR_W-1:0] char_out;
		logic [POS_W-1:0]  cursor_out;
		logic [POS_W-1:0]  length_out;
		logic              last_out;
	} kle_out_t;

	typedef enum logic [3:0] {
		OP_ESC, OP_RELEASE, OP_REPEAT, OP_SKIP, OP_LEFT, OP_RIGHT,
		OP_BKSP, OP_ENTER, OP_INSERT
	} op_t;

	typedef enum logic [1:0] {
		RD_HERE, RD_PREV, RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    decode;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_shift;
		logic    idx_inc;
		logic    idx_dec;
		logic    fin_ins;
		logic    fin_del;
		logic    put_char;
		logic    put_res;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic ins_more;
		logic del_more;
		logic send_more;
		logic out_free;
	} sts_t;

	function automatic logic [CHAR_W-1:0] key_to_char(input logic [KEY_W-1:0] k,
		input logic sh);
		logic [CHAR_W-1:0] c;
		logic [KEY_W-1:0]  off;
		c   = CHAR_NUL;
		off = k - KEY_A;
		if (k inside {[KEY_A:KEY_Z]}) begin
			c = (sh ? 7'h41 : 7'h61) + off[CHAR_W-1:0];
		end else if (k inside {[KEY_1:KEY_0]}) begin
			off = k - KEY_1;
			if (sh) begin
				c = SHIFT_DIGITS[off[3:0]];
			end else if (k == KEY_0) begin
				c = 7'h30;
			end else begin
				c = 7'h31 + off[CHAR_W-1:0];
			end
		end else begin
			case (k)
				KEY_SPACE:    c = 7'h20;
				KEY_MINUS:    c = sh ? 7'h5F : 7'h2D;
				KEY_EQUAL:    c = sh ? 7'h2B : 7'h3D;
				KEY_LBRACKET: c = sh ? 7'h7B : 7'h5B;
				KEY_RBRACKET: c = sh ? 7'h7D : 7'h5D;
				KEY_BSLASH:   c = sh ? 7'h7C : 7'h5C;
				KEY_SEMI:     c = sh ? 7'h3A : 7'h3B;
				KEY_QUOTE:    c = sh ? 7'h22 : 7'h27;
				KEY_GRAVE:    c = sh ? 7'h7E : 7'h60;
				KEY_COMMA:    c = sh ? 7'h3C : 7'h2C;
				KEY_PERIOD:   c = sh ? 7'h3E : 7'h2E;
				KEY_SLASH:    c = sh ? 7'h3F : 7'h2F;
				default:      c = CHAR_NUL;
			endcase
		end
		return c;
	endfunction

endpackage

@@ rtl/kle_ram.sv @@
module kle_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/kle_ctrl.sv @@
module kle_ctrl import kle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic key_valid,
	output logic key_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DECODE   = 9'b000000010,
		ST_INS_CHK  = 9'b000000100,
		ST_INS_WR   = 9'b000001000,
		ST_DEL_CHK  = 9'b000010000,
		ST_DEL_WR   = 9'b000100000,
		ST_SEND_CHK = 9'b001000000,
		ST_SEND_PUT = 9'b010000000,
		ST_RESULT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign key_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (key_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				case (sts.op)
					OP_BKSP:  state_d = ST_DEL_CHK;
					OP_INSERT: state_d = ST_INS_CHK;
					OP_ENTER: state_d = ST_SEND_CHK;
					default:  state_d = ST_RESULT;
				endcase
			end
			ST_INS_CHK: begin
				// shift tail up one slot, top entry first
				if (sts.ins_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_d    = ST_INS_WR;
				end else begin
					cmd.fin_ins = 1'b1;
					state_d     = ST_RESULT;
				end
			end
			ST_INS_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec  = 1'b1;
				state_d      = ST_INS_CHK;
			end
			ST_DEL_CHK: begin
				if (sts.del_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = ST_DEL_WR;
				end else begin
					cmd.fin_del = 1'b1;
					state_d     = ST_RESULT;
				end
			end
			ST_DEL_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = ST_DEL_CHK;
			end
			ST_SEND_CHK: begin
				if (sts.send_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HERE;
					state_d    = ST_SEND_PUT;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SEND_PUT: begin
				if (sts.out_free) begin
					cmd.put_char = 1'b1;
					cmd.idx_inc  = 1'b1;
					state_d      = ST_SEND_CHK;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.put_res = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/kle_dpath.sv @@
`include "keyboard_line_editor_top_macros.svh"

module kle_dpath import kle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  kle_in_t  key_data,
	input  cmd_t     cmd,
	output sts_t     sts,
	output logic     ev_valid,
	input  logic     ev_stall,
	output kle_out_t ev_data
);

	kle_in_t           in_q;
	logic [KEY_W-1:0]  prev_key_q;
	logic [POS_W-1:0]  len_q, cur_q, idx_q, cnt_q;
	logic [CHAR_W-1:0] ch_q, res_char_q;
	logic [1:0]        res_kind_q;
	logic              ev_valid_q;
	kle_out_t          ev_q;

	logic              shift;
	logic [CHAR_W-1:0] map_ch;
	op_t               op;
	logic [POS_W-1:0]  rd_addr, wr_addr;
	logic [CHAR_W-1:0] wr_data, rd_data;
	logic              wr_en;

	assign shift  = |(in_q.modifier_bits & SHIFT_MASK);
	assign map_ch = key_to_char(in_q.key_code, shift);

	always_comb begin
		if (in_q.key_code == KEY_ESC) begin
			op = OP_ESC;
		end else if (in_q.key_code == KEY_NONE) begin
			op = OP_RELEASE;
		end else if (in_q.key_code == prev_key_q) begin
			op = OP_REPEAT;
		end else if (in_q.key_code == KEY_LEFT) begin
			op = OP_LEFT;
		end else if (in_q.key_code == KEY_RIGHT) begin
			op = OP_RIGHT;
		end else if (in_q.key_code == KEY_BKSP) begin
			op = (cur_q == '0) ? OP_SKIP : OP_BKSP;
		end else if (in_q.key_code == KEY_ENTER) begin
			op = OP_ENTER;
		end else if (map_ch == CHAR_NUL || len_q >= CAPACITY) begin
			op = OP_SKIP;
		end else begin
			op = OP_INSERT;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PREV: rd_addr = idx_q - POS_W'(1);
			RD_NEXT: rd_addr = idx_q + POS_W'(1);
			default: rd_addr = idx_q;
		endcase
	end

	assign wr_en   = cmd.wr_shift | cmd.fin_ins;
	assign wr_addr = cmd.fin_ins ? cur_q : idx_q;
	assign wr_data = cmd.fin_ins ? ch_q : rd_data;

	kle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (STORE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign sts.op        = op;
	assign sts.ins_more  = (idx_q > cur_q);
	assign sts.del_more  = (({1'b0, idx_q} + (POS_W+1)'(1)) < {1'b0, len_q});
	assign sts.send_more = (idx_q < cnt_q);
	assign sts.out_free  = !ev_valid_q || !ev_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= KEY_NONE;
			len_q      <= '0;
			cur_q      <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			if (cmd.decode) begin
				case (op)
					OP_RELEASE: prev_key_q <= KEY_NONE;
					OP_ESC, OP_REPEAT: prev_key_q <= prev_key_q;
					default: prev_key_q <= in_q.key_code;
				endcase
				case (op)
					OP_LEFT: begin
						if (cur_q != '0) begin
							cur_q <= cur_q - POS_W'(1);
						end
					end
					OP_RIGHT: begin
						if (cur_q < len_q) begin
							cur_q <= cur_q + POS_W'(1);
						end
					end
					OP_ENTER: begin
						len_q <= '0;
						cur_q <= '0;
					end
					default: begin
						cur_q <= cur_q;
					end
				endcase
			end
			if (cmd.fin_ins) begin
				len_q <= len_q + POS_W'(1);
				cur_q <= cur_q + POS_W'(1);
			end
			if (cmd.fin_del) begin
				len_q <= len_q - POS_W'(1);
				cur_q <= cur_q - POS_W'(1);
			end
			if (cmd.put_char || cmd.put_res) begin
				ev_valid_q <= 1'b1;
			end else if (!ev_stall) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= key_data;
		end
		if (cmd.decode) begin
			ch_q <= map_ch;
			case (op)
				OP_BKSP: begin
					idx_q      <= cur_q - POS_W'(1);
					res_kind_q <= EV_EDIT;
					res_char_q <= CHAR_NUL;
				end
				OP_INSERT: begin
					idx_q      <= len_q;
					res_kind_q <= EV_EDIT;
					res_char_q <= map_ch;
				end
				OP_ENTER: begin
					idx_q      <= '0;
					cnt_q      <= len_q;
					res_kind_q <= EV_SEND;
					res_char_q <= CHAR_NEWLINE;
				end
				OP_LEFT, OP_RIGHT: begin
					res_kind_q <= EV_EDIT;
					res_char_q <= CHAR_NUL;
				end
				OP_ESC: begin
					res_kind_q <= EV_ESCAPE;
					res_char_q <= CHAR_NUL;
				end
				default: begin
					res_kind_q <= EV_IGNORED;
					res_char_q <= CHAR_NUL;
				end
			endcase
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + POS_W'(1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - POS_W'(1);
		end
		if (cmd.put_char) begin
			ev_q <= '{event_kind: EV_SEND, char_out: rd_data, cursor_out: cur_q,
				length_out: len_q, last_out: 1'b0};
		end else if (cmd.put_res) begin
			ev_q <= '{event_kind: res_kind_q, char_out: res_char_q, cursor_out: cur_q,
				length_out: len_q, last_out: 1'b1};
		end
	end

	assign ev_valid = ev_valid_q;
	assign ev_data  = ev_q;

	`KLE_ASSERT_NOW(a_cur_in_line, clk, arst_n, 1'b1, cur_q <= len_q, "cursor past line end")
	`KLE_ASSERT_NOW(a_len_cap, clk, arst_n, 1'b1, len_q <= CAPACITY, "line over capacity")
	`KLE_ASSERT_NOW(a_ins_end, clk, arst_n, cmd.fin_ins, idx_q == cur_q, "insert walk overran cursor")
	`KLE_ASSERT_NOW(a_del_end, clk, arst_n, cmd.fin_del, ({1'b0, idx_q} + (POS_W+1)'(1)) == {1'b0, len_q}, "delete walk end mismatch")
	`KLE_ASSERT_NEXT(a_enter_clr, clk, arst_n, cmd.decode && op == OP_ENTER, len_q == '0 && cur_q == '0, "enter left line")

endmodule

@@ rtl/keyboard_line_editor_top.sv @@
// Channel  Dir  Handshake            Beat fields
// key      in   key_valid/key_stall  key_code, modifier_bits
// ev       out  ev_valid/ev_stall    event_kind, char_out, cursor_out, length_out, last_out
//
// One report at a time: key_stall is high from the accepting edge until the final result
// beat is loaded; arrows, escape and ignored keys go through decode and result only.
// Insert and backspace move the tail one char at a time, a read then a write state each.
// Enter reads and sends each stored char in turn; a held ev_stall stalls each put.
// arst_n clears cursor, length, last key and handshake state; the line RAM is not
// cleared, only entries below the length are read. The next report is taken while
// the final result still waits in the output register.

module keyboard_line_editor_top import kle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	// key report channel
	input  logic     key_valid,
	output logic     key_stall,
	input  kle_in_t  key_data,
	// result channel
	output logic     ev_valid,
	input  logic     ev_stall,
	output kle_out_t ev_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: walks insert, delete and send loops
	kle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// line RAM, cursor/length, key decode and output register
	kle_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_data (key_data),
		.cmd      (cmd),
		.sts      (sts),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_data  (ev_data)
	);

endmodule
